[hdl/sss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sss_pkg
// Shared codes, reset values and record types of the supply supervisor
// sequencer.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Mode codes, as reported on mode_code
    localparam logic [2:0] MODE_WAIT    = 3'd0;
    localparam logic [2:0] MODE_TEST    = 3'd1;
    localparam logic [2:0] MODE_OPERATE = 3'd2;
    localparam logic [2:0] MODE_FAULT   = 3'd3;
    localparam logic [2:0] MODE_PERMA   = 3'd4;

    // Register reset values
    localparam logic [15:0] DEFAULT_POWER_UP_TICKS = 16'd1000;
    localparam logic [7:0]  DEFAULT_MAX_RESTARTS   = 8'd5;

    // Register indexes, taken from paddr[2]
    localparam logic REG_POWER_UP_TICKS = 1'b0;
    localparam logic REG_MAX_RESTARTS   = 1'b1;

    // Fault latch bit positions
    localparam int unsigned LATCH_OVP  = 0;
    localparam int unsigned LATCH_TEMP = 1;
    localparam int unsigned LATCH_COOL = 2;
    localparam int unsigned LATCH_LINK = 3;
    localparam int unsigned LATCH_HWIN = 4;
    localparam int unsigned LATCH_MWIN = 8;

    typedef struct packed {
        logic       tick;
        logic       configured;
        logic       heater_overvolt_pin;
        logic       temp_switch_pin;
        logic       coolant_fault;
        logic       reset_enable;
        logic       link_loss;
        logic [3:0] heater_window_flags;
        logic [3:0] magnet_window_flags;
        logic       relay_open_pin;
    } item_t;

    typedef struct packed {
        logic [15:0] power_up_ticks;
        logic [7:0]  max_restarts;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  restart_count;
        logic [15:0] test_timer;
        logic [11:0] fault_latch;
        logic        fault_now;
        logic        drive_enable;
        logic        ready_n;
        logic        perma_flag;
        logic        led_red;
        logic        relay_flag;
    } state_t;

endpackage
`default_nettype wire

[hdl/sss_pass.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sss_pass
// One control-loop pass: fault sampling, tick evaluation, mode check and
// entry actions, all combinational.
// ----------------------------------------------------------------------------
module sss_pass (
    input  wire sss_pkg::item_t  item,
    input  wire sss_pkg::cfg_t   cfg,
    input  wire sss_pkg::state_t cur,
    output sss_pkg::state_t      nxt
);

    always_comb
    begin
        sss_pkg::state_t st;
        logic [2:0]      next_mode;
        logic            win_active;

        st = cur;

        // Repair an impossible mode code into permanent fault
        if (st.mode > sss_pkg::MODE_PERMA)
        begin
            st.mode         = sss_pkg::MODE_PERMA;
            st.drive_enable = 1'b0;
            st.ready_n      = 1'b1;
            st.perma_flag   = 1'b1;
        end

        win_active = (st.mode == sss_pkg::MODE_TEST) || (st.mode == sss_pkg::MODE_OPERATE);

        // Pins latch on every pass
        if (item.heater_overvolt_pin)
        begin
            st.fault_latch[sss_pkg::LATCH_OVP] = 1'b1;
            st.fault_now = 1'b1;
        end
        if (item.temp_switch_pin)
        begin
            st.fault_latch[sss_pkg::LATCH_TEMP] = 1'b1;
            st.fault_now = 1'b1;
        end

        // Tick evaluation: timer, LED, relay, latches and live fault flag
        if (item.tick)
        begin
            if (st.mode == sss_pkg::MODE_TEST && st.test_timer != 16'hFFFF)
                st.test_timer = st.test_timer + 16'd1;
            st.led_red    = st.ready_n;
            st.relay_flag = item.relay_open_pin;
            st.fault_now  = item.heater_overvolt_pin | item.temp_switch_pin;
            if (item.coolant_fault)
            begin
                st.fault_latch[sss_pkg::LATCH_COOL] = 1'b1;
                st.fault_now = 1'b1;
            end
            else if (item.reset_enable)
                st.fault_latch[sss_pkg::LATCH_COOL] = 1'b0;
            if (item.link_loss)
            begin
                st.fault_latch[sss_pkg::LATCH_LINK] = 1'b1;
                st.fault_now = 1'b1;
            end
            if (win_active)
            begin
                st.fault_latch[sss_pkg::LATCH_HWIN +: 4] =
                    st.fault_latch[sss_pkg::LATCH_HWIN +: 4] | item.heater_window_flags;
                st.fault_latch[sss_pkg::LATCH_MWIN +: 4] =
                    st.fault_latch[sss_pkg::LATCH_MWIN +: 4] | item.magnet_window_flags;
                if (item.heater_window_flags != 4'd0 || item.magnet_window_flags != 4'd0)
                    st.fault_now = 1'b1;
            end
        end

        // Mode checks
        next_mode = st.mode;
        case (st.mode)
            sss_pkg::MODE_WAIT:
            begin
                if (item.configured)
                    next_mode = sss_pkg::MODE_TEST;
            end
            sss_pkg::MODE_TEST:
            begin
                if (st.test_timer >= cfg.power_up_ticks)
                begin
                    st.restart_count = 8'd0;
                    st.test_timer    = cfg.power_up_ticks;
                    if (st.fault_latch == 12'd0 || item.reset_enable)
                        next_mode = sss_pkg::MODE_OPERATE;
                end
                if (st.fault_now)
                    next_mode = (st.restart_count <= cfg.max_restarts) ?
                                sss_pkg::MODE_FAULT : sss_pkg::MODE_PERMA;
            end
            sss_pkg::MODE_OPERATE:
            begin
                if (st.fault_now)
                    next_mode = sss_pkg::MODE_FAULT;
            end
            sss_pkg::MODE_FAULT:
            begin
                if (!st.fault_now)
                    next_mode = sss_pkg::MODE_WAIT;
            end
            default:
            begin
                next_mode = st.mode;
            end
        endcase

        // Entry actions of a new mode
        if (next_mode != st.mode)
        begin
            st.mode = next_mode;
            case (next_mode)
                sss_pkg::MODE_WAIT:
                begin
                    st.ready_n      = 1'b1;
                    st.drive_enable = 1'b0;
                end
                sss_pkg::MODE_TEST:
                begin
                    if (st.restart_count != 8'hFF)
                        st.restart_count = st.restart_count + 8'd1;
                    st.ready_n      = 1'b1;
                    st.test_timer   = 16'd0;
                    st.drive_enable = 1'b1;
                end
                sss_pkg::MODE_OPERATE:
                begin
                    st.ready_n     = 1'b0;
                    st.fault_latch = 12'd0;
                end
                sss_pkg::MODE_FAULT:
                begin
                    st.drive_enable = 1'b0;
                    st.ready_n      = 1'b1;
                end
                default:
                begin
                    st.mode         = sss_pkg::MODE_PERMA;
                    st.drive_enable = 1'b0;
                    st.ready_n      = 1'b1;
                    st.perma_flag   = 1'b1;
                end
            endcase
        end

        nxt = st;
    end

endmodule
`default_nettype wire

[hdl/supply_supervisor_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// supply_supervisor_sequencer
// Mode sequencer and fault supervisor for a heater and magnet supply.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ---------------------------------
//  in       sink       in_valid / in_stall   one loop-pass event (10 fields)
//  out      source     out_valid / out_stall mode, enables, latches (8 fields)
//  cfg      APB slave  psel/penable/pwrite   power_up_ticks @0, max_restarts @4
//
//  One transaction is taken per clock while in_stall is low. The result
//  shows on the outputs after the input register and then the state/result
//  register; a stall on the result channel can hold it in between.
//  The pass logic between those two registers is a single combinational
//  unit; consecutive transactions flow without bubbles.
//  rst_n clears the mode state, the counters, the latches and both valid flags
//  asynchronously; the configuration registers return to their default values.
//  A stalled result holds; one more transaction waits in the input register,
//  and in_stall rises only when both stages are full.
//
module supply_supervisor_sequencer (
    input  wire         clk,
    input  wire         rst_n,

    // input channel
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         tick,
    input  wire         configured,
    input  wire         heater_overvolt_pin,
    input  wire         temp_switch_pin,
    input  wire         coolant_fault,
    input  wire         reset_enable,
    input  wire         link_loss,
    input  wire  [3:0]  heater_window_flags,
    input  wire  [3:0]  magnet_window_flags,
    input  wire         relay_open_pin,

    // result channel
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  mode_code,
    output logic        outputs_on,
    output logic        not_ready,
    output logic        perma_fault,
    output logic [11:0] latched_faults,
    output logic        live_fault,
    output logic        red_led,
    output logic        relay_status,

    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sss_pkg::item_t  item_reg;
    logic            item_valid_reg;
    logic            item_valid_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    sss_pkg::cfg_t   cfg_reg;
    sss_pkg::state_t state_reg;
    sss_pkg::state_t state_next;

    logic            in_take;
    logic            advance;
    logic            cfg_write;

    // ------------------------------------------------------------------------
    // Handshake: advance the held transaction when the result slot frees up
    // ------------------------------------------------------------------------
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign item_valid_next = in_take | (item_valid_reg & ~advance);
    assign out_valid_next  = advance | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input register: payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.tick                <= tick;
            item_reg.configured          <= configured;
            item_reg.heater_overvolt_pin <= heater_overvolt_pin;
            item_reg.temp_switch_pin     <= temp_switch_pin;
            item_reg.coolant_fault       <= coolant_fault;
            item_reg.reset_enable        <= reset_enable;
            item_reg.link_loss           <= link_loss;
            item_reg.heater_window_flags <= heater_window_flags;
            item_reg.magnet_window_flags <= magnet_window_flags;
            item_reg.relay_open_pin      <= relay_open_pin;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers; the low address bits are ignored
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_ticks <= sss_pkg::DEFAULT_POWER_UP_TICKS;
            cfg_reg.max_restarts   <= sss_pkg::DEFAULT_MAX_RESTARTS;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == sss_pkg::REG_POWER_UP_TICKS)
                cfg_reg.power_up_ticks <= pwdata[15:0];
            else
                cfg_reg.max_restarts <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == sss_pkg::REG_MAX_RESTARTS)
            prdata = {24'd0, cfg_reg.max_restarts};
        else
            prdata = {16'd0, cfg_reg.power_up_ticks};
    end

    // ------------------------------------------------------------------------
    // Loop pass and state/result register. The state only moves when a
    // transaction advances, so it doubles as the held result.
    // ------------------------------------------------------------------------
    sss_pass u_pass (
        .item (item_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= sss_pkg::MODE_WAIT;
            state_reg.restart_count <= 8'd0;
            state_reg.test_timer    <= 16'd0;
            state_reg.fault_latch   <= 12'd0;
            state_reg.fault_now     <= 1'b0;
            state_reg.drive_enable  <= 1'b0;
            state_reg.ready_n       <= 1'b1;
            state_reg.perma_flag    <= 1'b0;
            state_reg.led_red       <= 1'b0;
            state_reg.relay_flag    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode_code      = state_reg.mode;
    assign outputs_on     = state_reg.drive_enable;
    assign not_ready      = state_reg.ready_n;
    assign perma_fault    = state_reg.perma_flag;
    assign latched_faults = state_reg.fault_latch;
    assign live_fault     = state_reg.fault_now;
    assign red_led        = state_reg.led_red;
    assign relay_status   = state_reg.relay_flag;

`ifndef SYNTH
    // Not-ready tracks operate mode exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ready_n == (state_reg.mode != sss_pkg::MODE_OPERATE))
    else $error("not_ready out of step with mode");

    // Permanent fault flag only in permanent fault mode
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.perma_flag |-> (state_reg.mode == sss_pkg::MODE_PERMA))
    else $error("perma flag set outside permanent fault");

    // Drives are enabled only during power-up test or operate
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.drive_enable |-> (state_reg.mode == sss_pkg::MODE_TEST ||
                                    state_reg.mode == sss_pkg::MODE_OPERATE))
    else $error("drives enabled in a safe mode");

    // A held transaction with a free result slot must show up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !out_valid_reg) |=> out_valid_reg)
    else $error("held transaction did not advance");
`endif

endmodule
`default_nettype wire
